// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rho block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PRHO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prho check failed");

// Next-cycle implication, off while reset is high.
`define PRHO_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prho check failed");

`endif

// ===== design/prho_pkg.sv =====
// ----------------------------------------------------------------------------
// prho_pkg
// Types, codes and constants of the Pollard rho divisor finder.
// ----------------------------------------------------------------------------
package prho_pkg;

   localparam int WIDTH_DEF = 32;
   localparam int FIELD_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int ADDR_W    = 3;

   localparam logic [FIELD_W-1:0] START_RESET = 32'd1;
   localparam logic [FIELD_W-1:0] INCR_RESET  = 32'd5;

   localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAILED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   // register select, taken from paddr[2]
   localparam logic REG_START_VALUE = 1'b0;
   localparam logic REG_INCREMENT   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SQ_DIV,
      ST_DIFF,
      ST_GCD_CHK,
      ST_GCD_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STEP_TORT,
      STEP_HARE1,
      STEP_HARE2
   } step_type;

endpackage

// ===== design/pollard_rho_factor_finder.sv =====
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder
// Pollard rho divisor search with Floyd cycle detection, one shared
// restoring remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_number
//  rsp       out        rsp_valid/rsp_stall  rsp_divisor, rsp_status
//  apb       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Sequence: a number below two goes straight to the finish state, then the
//   result register loads. Otherwise each rho round runs three squarings, each
//   a multiply, an add of the increment and a reduction mod n, then the
//   difference and a loop of gcd checks and Euclid remainders; reductions take
//   one quotient bit a cycle in the restoring remainder unit. The finish state ends every search.
// Reset: synchronous, active high; sequencer idle, result register empty,
//   start_value back to 1 and increment back to 5.
// Stalls: req_stall is high from acceptance until the result is loaded into
//   the output register; a held result does not block the next transaction.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder #(
   parameter int WIDTH = prho_pkg::WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [prho_pkg::FIELD_W-1:0]     req_number,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [prho_pkg::FIELD_W-1:0]     rsp_divisor,
   output logic [prho_pkg::STATUS_W-1:0]    rsp_status,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [prho_pkg::ADDR_W-1:0]      paddr,
   input  logic [prho_pkg::FIELD_W-1:0]     pwdata,
   output logic [prho_pkg::FIELD_W-1:0]     prdata,
   output logic                             pready
);
   import prho_pkg::*;

   localparam int PROD_W = 2 * WIDTH;
   localparam int CNT_W  = $clog2(PROD_W + 1);
   localparam logic [CNT_W-1:0] SQ_STEPS  = CNT_W'(PROD_W);
   localparam logic [CNT_W-1:0] GCD_STEPS = CNT_W'(WIDTH);

   // sequencer and datapath registers
   state_type               state_ff,  state_in;
   step_type                step_ff,   step_in;
   logic [WIDTH-1:0]        start_ff,  start_in;
   logic [WIDTH-1:0]        incr_ff,   incr_in;
   logic [WIDTH-1:0]        n_ff,      n_in;
   logic [WIDTH-1:0]        tort_ff,   tort_in;
   logic [WIDTH-1:0]        hare_ff,   hare_in;
   logic [WIDTH-1:0]        larger_ff, larger_in;
   logic [WIDTH-1:0]        smaller_ff, smaller_in;
   logic [PROD_W-1:0]       dividend_ff, dividend_in;
   logic [WIDTH-1:0]        rem_ff,    rem_in;
   logic [CNT_W-1:0]        count_ff,  count_in;
   logic [WIDTH-1:0]        res_div_ff, res_div_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]      rsp_divisor_ff, rsp_divisor_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic                    req_accept;
   logic                    rsp_free;
   logic                    cfg_write;
   logic [WIDTH-1:0]        n_req;
   logic                    n_small;
   logic [WIDTH-1:0]        operand;
   logic [PROD_W-1:0]       square;
   logic [WIDTH-1:0]        diff;
   logic [WIDTH-1:0]        den;
   logic [WIDTH:0]          trial;
   logic [WIDTH:0]          trial_sub;
   logic [WIDTH-1:0]        rem_step;
   logic                    last_step;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_write  = psel && penable && pwrite;

   assign n_req   = req_number[WIDTH-1:0];
   assign n_small = (n_req < WIDTH'(2));

   // squaring operand: tortoise on its step, hare on both of its steps
   assign operand = (step_ff == STEP_TORT) ? tort_ff : hare_ff;
   assign square  = PROD_W'(operand) * PROD_W'(operand);
   assign diff    = (tort_ff >= hare_ff) ? (tort_ff - hare_ff) : (hare_ff - tort_ff);

   // shared restoring remainder step: one dividend bit per cycle
   assign den       = (state_ff == ST_GCD_DIV) ? smaller_ff : n_ff;
   assign trial     = {rem_ff, dividend_ff[PROD_W-1]};
   assign trial_sub = trial - {1'b0, den};
   assign rem_step  = (trial >= {1'b0, den}) ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
   assign last_step = (count_ff == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = n_small ? ST_FINISH : ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = ST_SQ_DIV;
         ST_SQ_DIV: begin
            if (last_step) begin
               state_in = (step_ff == STEP_HARE2) ? ST_DIFF : ST_MUL;
            end
         end
         ST_DIFF:   state_in = ST_GCD_CHK;
         ST_GCD_CHK: begin
            if (smaller_ff == '0) begin
               // gcd of one means another round
               state_in = (larger_ff == WIDTH'(1)) ? ST_MUL : ST_FINISH;
            end else begin
               state_in = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            if (last_step) begin
               state_in = ST_GCD_CHK;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      step_in        = step_ff;
      n_in           = n_ff;
      tort_in        = tort_ff;
      hare_in        = hare_ff;
      larger_in      = larger_ff;
      smaller_in     = smaller_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      count_in       = count_ff;
      res_div_in     = res_div_ff;
      res_status_in  = res_status_ff;
      rsp_divisor_in = rsp_divisor_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               n_in    = n_req;
               tort_in = start_ff;
               hare_in = start_ff;
               step_in = STEP_TORT;
               if (n_small) begin
                  res_div_in    = '0;
                  res_status_in = STATUS_INVALID;
               end
            end
         end
         ST_MUL: begin
            dividend_in = square;
         end
         ST_ADD: begin
            dividend_in = dividend_ff + PROD_W'(incr_ff);
            rem_in      = '0;
            count_in    = SQ_STEPS;
         end
         ST_SQ_DIV: begin
            dividend_in = dividend_ff << 1;
            rem_in      = rem_step;
            count_in    = count_ff - CNT_W'(1);
            if (last_step) begin
               case (step_ff)
                  STEP_TORT: begin
                     tort_in = rem_step;
                     step_in = STEP_HARE1;
                  end
                  STEP_HARE1: begin
                     hare_in = rem_step;
                     step_in = STEP_HARE2;
                  end
                  default: begin
                     hare_in = rem_step;
                  end
               endcase
            end
         end
         ST_DIFF: begin
            larger_in  = n_ff;
            smaller_in = diff;
         end
         ST_GCD_CHK: begin
            if (smaller_ff == '0) begin
               if (larger_ff == WIDTH'(1)) begin
                  step_in = STEP_TORT;
               end else if (larger_ff < n_ff) begin
                  res_div_in    = larger_ff;
                  res_status_in = STATUS_FOUND;
               end else begin
                  res_div_in    = '0;
                  res_status_in = STATUS_FAILED;
               end
            end else begin
               dividend_in = {larger_ff, WIDTH'(0)};
               rem_in      = '0;
               count_in    = GCD_STEPS;
            end
         end
         ST_GCD_DIV: begin
            dividend_in = dividend_ff << 1;
            rem_in      = rem_step;
            count_in    = count_ff - CNT_W'(1);
            if (last_step) begin
               larger_in  = smaller_ff;
               smaller_in = rem_step;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = FIELD_W'(res_div_ff);
               rsp_status_in  = res_status_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // register port: decode on paddr[2] only
   always_comb begin
      start_in = start_ff;
      incr_in  = incr_ff;
      if (cfg_write) begin
         if (paddr[2] == REG_INCREMENT) begin
            incr_in = pwdata[WIDTH-1:0];
         end else begin
            start_in = pwdata[WIDTH-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_START_VALUE) ? FIELD_W'(start_ff) : FIELD_W'(incr_ff);
   assign pready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;
   assign rsp_status  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_TORT;
         start_ff      <= START_RESET[WIDTH-1:0];
         incr_ff       <= INCR_RESET[WIDTH-1:0];
         tort_ff       <= '0;
         hare_ff       <= '0;
         larger_ff     <= '0;
         smaller_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         start_ff      <= start_in;
         incr_ff       <= incr_in;
         tort_ff       <= tort_in;
         hare_ff       <= hare_in;
         larger_ff     <= larger_in;
         smaller_ff    <= smaller_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      count_ff       <= count_in;
      res_div_ff     <= res_div_in;
      res_status_ff  <= res_status_in;
      rsp_divisor_ff <= rsp_divisor_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule

// ===== design/prho_checker.sv =====
// ----------------------------------------------------------------------------
// prho_checker
// Port-level checks on the rho divisor finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prho_checker #(
   parameter int WIDTH = prho_pkg::WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [prho_pkg::FIELD_W-1:0]  req_number,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [prho_pkg::FIELD_W-1:0]  rsp_divisor,
   input logic [prho_pkg::STATUS_W-1:0] rsp_status
);
   import prho_pkg::*;

   // a found divisor is nontrivial
   `PRHO_ASSERT_IMP(a_found_nontrivial, clock, reset, rsp_valid && (rsp_status == STATUS_FOUND), rsp_divisor > 32'd1)

   // no divisor reported on failure or invalid number
   `PRHO_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && (rsp_status != STATUS_FOUND), rsp_divisor == '0)

   // a real search holds off the next transaction
   `PRHO_ASSERT_NXT(a_search_busy, clock, reset, req_valid && !req_stall && (req_number[WIDTH-1:0] > WIDTH'(1)), req_stall)

   // a stalled response holds
   `PRHO_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_divisor) && $stable(rsp_status))

endmodule

bind pollard_rho_factor_finder prho_checker #(.WIDTH(WIDTH)) u_prho_checker (.*);

// ===== bench/tb_pollard_rho_factor_finder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pollard_rho_factor_finder
// Self-checking bench for the Pollard rho divisor finder: a directed table
// followed by random phases under several register settings, each response
// transaction compared with a typed-in answer or a local rho/Euclid predictor.
// ----------------------------------------------------------------------------
module tb_pollard_rho_factor_finder;
   import prho_pkg::*;

   localparam int W = WIDTH_DEF;
   localparam logic [63:0] VALUE_MASK = (64'd1 << W) - 64'd1;

   // rough cycle cost of one rho round and of one Euclid remainder, used only
   // to keep the random numbers cheap enough for the run length
   localparam longint unsigned ROUND_CYCLES = 3 * (2 * W + 2) + 2;
   localparam longint unsigned REM_CYCLES   = W + 1;
   localparam longint unsigned CHEAP_CAP    = 4000;
   localparam longint unsigned COSTLY_CAP   = 40000;
   localparam longint unsigned NO_CAP       = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 24;
   localparam int QUIET_ITEMS     = 20;    // tail of the run with no idling
   localparam int COSTLY_EVERY    = 14;    // one in this many may be slow
   localparam int HOLD_CYCLES     = 12000; // long receiver hold-off
   localparam int TAIL_CYCLES     = 200;

   localparam logic [ADDR_W-1:0] ADDR_START = {REG_START_VALUE, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_INCR  = {REG_INCREMENT, 2'b00};

   typedef struct packed {
      logic [FIELD_W-1:0]  divisor;
      logic [STATUS_W-1:0] status;
   } factor_type;

   // one directed row: register setting, number, and a typed-in answer
   // where it is obvious
   typedef struct packed {
      logic [31:0]         start;
      logic [31:0]         incr;
      logic [31:0]         number;
      logic                pinned;
      logic [31:0]         divisor;
      logic [STATUS_W-1:0] status;
   } probe_type;

   localparam int PROBE_COUNT = 22;

   probe_type probes [PROBE_COUNT] = '{
      // reset setting: below two, tiny numbers, field extremes
      '{32'd1, 32'd5, 32'd0,          1'b1, 32'd0, STATUS_INVALID},
      '{32'd1, 32'd5, 32'd1,          1'b1, 32'd0, STATUS_INVALID},
      '{32'd1, 32'd5, 32'd2,          1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'd3,          1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'd4,          1'b0, 32'd0, STATUS_FOUND},
      // 6 and 41 after one round, |6-41| = 35 shares only 5 with 2^32-1
      '{32'd1, 32'd5, 32'hFFFF_FFFF,  1'b1, 32'd5, STATUS_FOUND},
      '{32'd1, 32'd5, 32'hFFFF_FFFE,  1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'h8000_0000,  1'b0, 32'd0, STATUS_FOUND},
      // prime 101: sequences collide, search fails; then composite numbers
      '{32'd1, 32'd5, 32'd101,        1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'd8051,       1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'd10403,      1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'h0000_AAAA,  1'b0, 32'd0, STATUS_FOUND},
      '{32'd1, 32'd5, 32'h5555_5555,  1'b0, 32'd0, STATUS_FOUND},
      // start value far above n: first squaring on the raw value
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2,         1'b0, 32'd0, STATUS_FOUND},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7,         1'b0, 32'd0, STATUS_FOUND},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd91,        1'b0, 32'd0, STATUS_FOUND},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 1'b0, 32'd0, STATUS_FOUND},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, STATUS_FOUND},
      // zero start, zero increment: gcd(0, n) = n on the first round; then start 5, zero increment
      '{32'd0, 32'd0, 32'd12,         1'b1, 32'd0, STATUS_FAILED},
      '{32'd0, 32'd0, 32'hFFFF_FFFF,  1'b1, 32'd0, STATUS_FAILED},
      '{32'd5, 32'd0, 32'h0001_0000,  1'b0, 32'd0, STATUS_FOUND},
      '{32'd5, 32'd0, 32'd15,         1'b0, 32'd0, STATUS_FOUND}
   };

   // ------------------------------------------------------------------------
   // DUT connections, every input at a known value from time zero
   // ------------------------------------------------------------------------
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [FIELD_W-1:0]  req_number  = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [FIELD_W-1:0]  rsp_divisor;
   logic [STATUS_W-1:0] rsp_status;
   logic                psel        = 1'b0;
   logic                penable     = 1'b0;
   logic                pwrite      = 1'b0;
   logic [ADDR_W-1:0]   paddr       = '0;
   logic [FIELD_W-1:0]  pwdata      = '0;
   logic [FIELD_W-1:0]  prdata;
   logic                pready;

   // bench-side sideband that travels with each request transaction, so the
   // acceptance monitor knows whether the row carries a typed-in answer
   logic                req_pinned         = 1'b0;
   factor_type          req_pinned_outcome = '0;

   // predictor's copy of the registers
   logic [63:0]         cfg_start = {32'd0, START_RESET};
   logic [63:0]         cfg_incr  = {32'd0, INCR_RESET};

   factor_type          pending_factors [$];
   int                  mismatch_count = 0;
   bit                  quiet          = 1'b0;
   bit                  hold_pending   = 1'b0;

   pollard_rho_factor_finder #(
      .WIDTH (W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_divisor (rsp_divisor),
      .rsp_status  (rsp_status),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #24_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor: rho with Floyd, Euclid by remainders, gcd(0, n) = n.
   // Also reckons a rough cycle count; past cost_cap it gives up (only the
   // number picker uses a cap).
   // ------------------------------------------------------------------------
   function automatic factor_type rho_search(input logic [31:0] number,
                                             input longint unsigned cost_cap,
                                             output bit gave_up);
      logic [63:0]       n, tort, hare, diff, big, little, rem;
      longint unsigned   cycles;
      bit                done;
      factor_type        res;
      n       = {32'd0, number} & VALUE_MASK;
      gave_up = 1'b0;
      res     = '0;
      if (n < 64'd2) begin
         res.status = STATUS_INVALID;
         return res;
      end
      // the square of a full-width start plus increment still fits 64 bits
      tort   = cfg_start;
      hare   = cfg_start;
      big    = n;
      cycles = 0;
      done   = 1'b0;
      while (!done) begin
         tort   = (tort * tort + cfg_incr) % n;
         hare   = (hare * hare + cfg_incr) % n;
         hare   = (hare * hare + cfg_incr) % n;
         diff   = (tort >= hare) ? tort - hare : hare - tort;
         big    = n;
         little = diff;
         cycles += ROUND_CYCLES;
         while (little != 64'd0) begin
            rem    = big % little;
            big    = little;
            little = rem;
            cycles += REM_CYCLES;
         end
         if (big != 64'd1) begin
            done = 1'b1;
         end else if (cycles > cost_cap) begin
            done    = 1'b1;
            gave_up = 1'b1;
         end
      end
      if (big < n) begin
         res.divisor = big[FIELD_W-1:0];
         res.status  = STATUS_FOUND;
      end else begin
         res.status  = STATUS_FAILED;
      end
      return res;
   endfunction

   // Random number under the current setting. Mostly narrow values, some full
   // width, a little below-two noise; anything too slow is redrawn, which
   // mainly throws out large primes.
   function automatic logic [31:0] draw_number(input bit costly_ok);
      logic [31:0]     cand;
      int              kind;
      int              w;
      bit              gave_up;
      factor_type      unused;
      longint unsigned cap;
      cap = costly_ok ? COSTLY_CAP : CHEAP_CAP;
      do begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            cand = $urandom_range(0, 1);
         end else if (kind < 30) begin
            cand = $urandom;
         end else begin
            w    = $urandom_range(2, 31);
            cand = $urandom & ((32'd1 << w) - 32'd1);
         end
         unused = rho_search(cand, cap, gave_up);
      end while (gave_up);
      return cand;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // ------------------------------------------------------------------------
   // Monitor and receiver. The monitor samples on the rising edge, so it sees the
   // values that held before it, whatever order the processes run in.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : transaction_check
      factor_type want;
      bit         unused_flag;
      if (!reset) begin
         // request transaction accepted: predict its answer now, while the
         // register copy matches what the block sees
         if (req_valid && !req_stall) begin
            if (req_pinned)
               pending_factors.push_back(req_pinned_outcome);
            else
               pending_factors.push_back(rho_search(req_number, NO_CAP, unused_flag));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_factors.size() == 0) begin
               note_mismatch("unexpected response", 64'd0, {30'd0, rsp_status, rsp_divisor});
            end else begin
               want = pending_factors.pop_front();
               if (rsp_divisor !== want.divisor)
                  note_mismatch("divisor", {32'd0, want.divisor}, {32'd0, rsp_divisor});
               if (rsp_status !== want.status)
                  note_mismatch("status", {62'd0, want.status}, {62'd0, rsp_status});
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request so the block
   // fills up and pushes back on the sender, and no stalls in the quiet tail.
   initial begin : receiver
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            span = 0;
            while (span < HOLD_CYCLES) begin
               @(posedge clock);
               span++;
            end
            hold_pending = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Hold one request transaction until accepted. Valid stays high on return;
   // the caller either offers the next one or lowers it.
   task automatic offer(input logic [31:0] number, input bit pinned,
                        input factor_type outcome);
      req_valid          <= 1'b1;
      req_number         <= number;
      req_pinned         <= pinned;
      req_pinned_outcome <= outcome;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic rest(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // lower valid and wait until every predicted response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_factors.size() != 0) @(posedge clock);
   endtask

   // APB write: setup, access, then an idle step with psel low so back-to-back
   // calls never drive the same signal twice in one step
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_START)
         cfg_start = {32'd0, data} & VALUE_MASK;
      else if (addr == ADDR_INCR)
         cfg_incr = {32'd0, data} & VALUE_MASK;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [ADDR_W-1:0] addr, input logic [63:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want[FIELD_W-1:0])
         note_mismatch(addr == ADDR_START ? "start_value readback" : "increment readback",
                       want, {32'd0, prdata});
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [31:0] start, input logic [31:0] incr);
      csr_write(ADDR_START, start);
      csr_write(ADDR_INCR, incr);
      csr_check(ADDR_START, cfg_start);
      csr_check(ADDR_INCR, cfg_incr);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: reset, register defaults, directed table, random phases
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int          k;
      int          p;
      int          j;
      logic [31:0] s_val;
      logic [31:0] i_val;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(ADDR_START, {32'd0, START_RESET});
      csr_check(ADDR_INCR, {32'd0, INCR_RESET});

      // directed table; registers only change once the block has gone idle
      for (k = 0; k < PROBE_COUNT; k++) begin
         if (probes[k].start != cfg_start[31:0] || probes[k].incr != cfg_incr[31:0]) begin
            drain();
            set_registers(probes[k].start, probes[k].incr);
         end
         if ($urandom_range(0, 3) == 0)
            rest($urandom_range(1, 13));
         offer(probes[k].number, probes[k].pinned, {probes[k].divisor, probes[k].status});
      end

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin
               s_val = $urandom;
               i_val = $urandom;
            end
            1: begin
               s_val = 32'd0;
               i_val = 32'd0;
            end
            2: begin
               s_val = 32'hFFFF_FFFF;
               i_val = 32'hFFFF_FFFF;
            end
            3: begin
               s_val = $urandom_range(0, 15);
               i_val = $urandom;
            end
            default: begin
               s_val = $urandom;
               i_val = $urandom_range(0, 15);
            end
         endcase
         set_registers(s_val, i_val);
         // cheap collisions in this phase let the block fill up during the
         // long receiver hold-off
         if (p == 1)
            hold_pending = 1'b1;
         for (j = 0; j < ITEMS_PER_PHASE; j++) begin
            if (p == PHASES - 1 && j >= ITEMS_PER_PHASE - QUIET_ITEMS)
               quiet = 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
               rest($urandom_range(1, 13));
            offer(draw_number(((p * ITEMS_PER_PHASE + j) % COSTLY_EVERY) == COSTLY_EVERY - 1),
                  1'b0, '0);
         end
      end

      drain();
      // catch any stray response after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_factors.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
